/* rtl/core/lwecd_pkg.sv */
// Shared constants and types for the LWE clue detection block.
`timescale 1ns / 1ps
`default_nettype none

package lwecd_pkg;

    localparam int VECTOR_LENGTH = 25;
    localparam int IDX_W         = $clog2(VECTOR_LENGTH);
    localparam int POS_W         = 5;
    localparam int VAL_W         = 17;
    localparam int THR_W         = 16;
    localparam int PROD_W        = 2 * VAL_W;

    localparam logic [VAL_W-1:0] PRIME_MOD = 17'd65537;
    localparam logic [VAL_W-1:0] HALF_MOD  = 17'd32768;
    localparam logic [THR_W-1:0] THR_RESET = 16'd17;

    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_CLUE   = 2'd1;
    localparam logic [1:0] CMD_OFFSET = 2'd2;

    // One item handed from the input stage to the multiply-accumulate unit.
    typedef struct packed {
        logic             offset;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] key;
    } mac_item_t;

endpackage

`default_nettype wire

/* rtl/core/lwe_clue_detection.sv */
// Top level of the LWE clue detection block.
`timescale 1ns / 1ps
`default_nettype none

// Clue detection against a 25-entry secret vector modulo the prime 65537.
// Each input beat carries a command in tuser: 0 loads one key element, 1
// multiplies a clue element with the key element at the same position and
// adds it into the running sum, and 2 closes the clue with its offset. Only
// the offset beat yields an output beat, holding the centred difference
// (offset minus sum, mapped to -32768..32768) and a detected flag that is set
// when its magnitude is strictly below the threshold register; the running
// sum then clears. Key loads and clue elements at a position of 25 or more,
// and command 3, are consumed without effect. A key load is written into the
// key RAM at the edge that accepts it, and a clue element reads its key
// element from that RAM at the edge that accepts it, so the key data lands
// beside the input register. The block takes one beat in every cycle unless
// backpressure holds an offset item: the pipeline runs input register, 17x17
// product register, fold-and-accumulate register, difference register and
// output register. Backpressure only stalls the pipeline when an offset item
// cannot move on; key and clue beats keep flowing while a finished result
// waits. A key element must be loaded before any clue element reads it. The
// threshold must be written through cfg_wr_en/cfg_wr_data only while no clue
// is in flight (the block itself does not enforce this) and resets to 17.
module lwe_clue_detection (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,    // detect_threshold
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // position[4:0], value[21:5], zero fill
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // centred_difference[16:0], zero fill
    output logic             m_axis_tuser    // detected
);
    import lwecd_pkg::*;

    logic [THR_W-1:0] thr_reg;

    logic [1:0]       in_cmd;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_value;
    logic [VAL_W-1:0] in_value_red;
    logic             in_pos_ok;
    logic             in_keep;
    logic             in_accept;
    logic             key_wr;
    logic             key_rd;

    // Input register stage.
    logic             a_valid_reg;
    logic             a_valid_next;
    logic [1:0]       a_cmd_reg;
    logic [VAL_W-1:0] a_value_reg;
    logic             a_adv;

    logic [VAL_W-1:0] key_data;
    mac_item_t        mac_item;
    logic             mac_valid;
    logic             mac_ready;
    logic             diff_valid;
    logic             diff_ready;
    logic [VAL_W-1:0] diff;
    logic             res_detected;
    logic [VAL_W-1:0] res_centred;

    assign in_cmd   = s_axis_tuser;
    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_value = s_axis_tdata[POS_W+VAL_W-1:POS_W];

    // Values of 65537 and above are brought into range by one subtraction.
    assign in_value_red = (in_value >= PRIME_MOD) ? in_value - PRIME_MOD : in_value;

    assign in_pos_ok = in_pos < POS_W'(VECTOR_LENGTH);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Key loads finish at acceptance by writing the RAM; clue elements read
    // their key element at acceptance.
    assign key_wr = in_accept && (in_cmd == CMD_KEY) && in_pos_ok;
    assign key_rd = in_accept && (in_cmd == CMD_CLUE) && in_pos_ok;

    // Only offsets and in-range clue elements enter the pipeline.
    assign in_keep = (in_cmd == CMD_OFFSET) || ((in_cmd == CMD_CLUE) && in_pos_ok);

    assign a_adv         = a_valid_reg && mac_ready;
    assign s_axis_tready = !a_valid_reg || a_adv;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_accept && in_keep)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            thr_reg     <= THR_RESET;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_keep)
        begin
            a_cmd_reg   <= in_cmd;
            a_value_reg <= in_value_red;
        end
    end

    lwecd_key_store #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_LENGTH)
    ) u_key_store (
        .clk     (clk),
        .wr_en   (key_wr),
        .wr_addr (in_pos[IDX_W-1:0]),
        .wr_data (in_value_red),
        .rd_en   (key_rd),
        .rd_addr (in_pos[IDX_W-1:0]),
        .rd_data (key_data)
    );

    assign mac_valid       = a_valid_reg;
    assign mac_item.offset = a_cmd_reg == CMD_OFFSET;
    assign mac_item.value  = a_value_reg;
    assign mac_item.key    = key_data;

    lwecd_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mac_valid),
        .in_ready   (mac_ready),
        .in_item    (mac_item),
        .diff_valid (diff_valid),
        .diff_ready (diff_ready),
        .diff       (diff)
    );

    lwecd_centre u_centre (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (thr_reg),
        .diff_valid (diff_valid),
        .diff_ready (diff_ready),
        .diff       (diff),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .detected   (res_detected),
        .centred    (res_centred)
    );

    assign m_axis_tdata = {{(24-VAL_W){1'b0}}, res_centred};
    assign m_axis_tuser = res_detected;

endmodule

`default_nettype wire

/* rtl/core/lwecd_key_store.sv */
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lwecd_key_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    // Entries hold nothing meaningful until they are written.
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/lwecd_mac.sv */
// Modular multiply, fold mod 65537, accumulate and offset difference stages.
`timescale 1ns / 1ps
`default_nettype none

module lwecd_mac (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire lwecd_pkg::mac_item_t        in_item,
    output logic                             diff_valid,
    input  wire logic                        diff_ready,
    output logic      [lwecd_pkg::VAL_W-1:0] diff
);
    import lwecd_pkg::*;

    localparam logic signed [VAL_W+1:0] PRIME_S = (VAL_W+2)'(PRIME_MOD);

    // Product stage.
    logic              b_valid_reg;
    logic              b_valid_next;
    logic              b_offset_reg;
    logic [VAL_W-1:0]  b_value_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic              b_adv;

    // Reduced term stage.
    logic              c_valid_reg;
    logic              c_valid_next;
    logic              c_offset_reg;
    logic [VAL_W-1:0]  c_value_reg;
    logic [VAL_W-1:0]  c_value_next;
    logic              c_ready;
    logic              c_adv;

    // Difference stage.
    logic              d_valid_reg;
    logic              d_valid_next;
    logic [VAL_W-1:0]  d_diff_reg;
    logic [VAL_W-1:0]  d_diff_next;
    logic              d_ready;

    logic [VAL_W-1:0]  sum_reg;
    logic [VAL_W-1:0]  sum_next;

    logic signed [VAL_W+1:0] fold;
    logic signed [VAL_W+1:0] fold_adj;
    logic [VAL_W:0]          acc;
    logic [VAL_W:0]          acc_red;
    logic [VAL_W:0]          wrap_diff;

    assign d_ready  = !d_valid_reg || diff_ready;
    assign c_adv    = c_valid_reg && (!c_offset_reg || d_ready);
    assign c_ready  = !c_valid_reg || c_adv;
    assign b_adv    = b_valid_reg && c_ready;
    assign in_ready = !b_valid_reg || b_adv;

    // Since 2^16 is -1 mod 65537, p = a2*2^32 + a1*2^16 + a0 folds to a0 - a1 + a2.
    always_comb
    begin
        fold = $signed({3'b000, b_prod_reg[15:0]})
             - $signed({3'b000, b_prod_reg[31:16]})
             + $signed({{(VAL_W+2-(PROD_W-32)){1'b0}}, b_prod_reg[PROD_W-1:32]});
        if (fold < 0)
        begin
            fold_adj = fold + PRIME_S;
        end
        else if (fold >= PRIME_S)
        begin
            fold_adj = fold - PRIME_S;
        end
        else
        begin
            fold_adj = fold;
        end
        c_value_next = b_offset_reg ? b_value_reg : fold_adj[VAL_W-1:0];
    end

    always_comb
    begin
        acc     = {1'b0, sum_reg} + {1'b0, c_value_reg};
        acc_red = (acc >= {1'b0, PRIME_MOD}) ? acc - {1'b0, PRIME_MOD} : acc;
        if (c_value_reg >= sum_reg)
        begin
            wrap_diff = {1'b0, c_value_reg} - {1'b0, sum_reg};
        end
        else
        begin
            wrap_diff = {1'b0, c_value_reg} + {1'b0, PRIME_MOD} - {1'b0, sum_reg};
        end
        d_diff_next = wrap_diff[VAL_W-1:0];

        sum_next = sum_reg;
        if (c_adv)
        begin
            sum_next = c_offset_reg ? '0 : acc_red[VAL_W-1:0];
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (in_valid && in_ready)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_adv)
        begin
            b_valid_next = 1'b0;
        end

        c_valid_next = c_valid_reg;
        if (b_adv)
        begin
            c_valid_next = 1'b1;
        end
        else if (c_adv)
        begin
            c_valid_next = 1'b0;
        end

        d_valid_next = d_valid_reg;
        if (c_adv && c_offset_reg)
        begin
            d_valid_next = 1'b1;
        end
        else if (diff_ready)
        begin
            d_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            b_offset_reg <= in_item.offset;
            b_value_reg  <= in_item.value;
            b_prod_reg   <= PROD_W'(in_item.value) * PROD_W'(in_item.key);
        end
        if (b_adv)
        begin
            c_offset_reg <= b_offset_reg;
            c_value_reg  <= c_value_next;
        end
        if (c_adv && c_offset_reg)
        begin
            d_diff_reg <= d_diff_next;
        end
    end

    assign diff_valid = d_valid_reg;
    assign diff       = d_diff_reg;

    // The running sum is always a reduced residue.
    assert property (@(posedge clk) disable iff (!rst_n) sum_reg < PRIME_MOD)
        else $error("running sum left the residue range");

    // A closing offset clears the sum for the next clue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_adv && c_offset_reg) |=> (sum_reg == '0))
        else $error("running sum not cleared after offset");

    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (d_diff_reg < PRIME_MOD))
        else $error("difference left the residue range");

endmodule

`default_nettype wire

/* rtl/core/lwecd_centre.sv */
// Centring of the difference, threshold compare and output register.
`timescale 1ns / 1ps
`default_nettype none

module lwecd_centre (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lwecd_pkg::THR_W-1:0] threshold,
    input  wire logic                        diff_valid,
    output logic                             diff_ready,
    input  wire logic [lwecd_pkg::VAL_W-1:0] diff,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             detected,
    output logic      [lwecd_pkg::VAL_W-1:0] centred
);
    import lwecd_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             detected_reg;
    logic             detected_next;
    logic [VAL_W-1:0] centred_reg;
    logic [VAL_W-1:0] centred_next;
    logic [VAL_W-1:0] magnitude;
    logic             upper_half;

    assign diff_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        upper_half = diff > HALF_MOD;
        // In the upper half the value stands for diff - 65537, a negative number.
        centred_next  = upper_half ? diff - PRIME_MOD : diff;
        magnitude     = upper_half ? PRIME_MOD - diff : diff;
        detected_next = magnitude < {1'b0, threshold};

        out_valid_next = out_valid_reg;
        if (diff_valid && diff_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (diff_valid && diff_ready)
        begin
            detected_reg <= detected_next;
            centred_reg  <= centred_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign detected  = detected_reg;
    assign centred   = centred_reg;

    // A centred result never falls below -32768.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !($signed(centred_reg) < $signed(17'h18000)))
        else $error("centred difference below range");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the LWE clue detection block.
`timescale 1ns / 1ps

module tb;
    import lwecd_pkg::*;

    // Command 3 has no name in the package; the block consumes it without effect.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned MODULUS      = PRIME_MOD;
    localparam int unsigned HALF_RANGE   = HALF_MOD;
    localparam int unsigned RAW_MAX      = (1 << VAL_W) - 1;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          QUIET_LIMIT  = 5000;
    localparam int          PHASE_ITEMS  = 55;
    localparam int          PHASE_COUNT  = 5;
    localparam int          MAX_SHOWN    = 10;

    typedef struct {
        logic                    detected;
        logic signed [VAL_W-1:0] centred;
    } verdict_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [15:0]      cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata;
    logic [1:0]       s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [23:0]      m_axis_tdata;
    logic             m_axis_tuser;

    // Shadow copy of the block's state, updated as each input beat is accepted.
    logic [VAL_W-1:0] secret_copy [VECTOR_LENGTH];
    bit               key_loaded [VECTOR_LENGTH];
    int unsigned      clue_sum;
    int unsigned      threshold_q;
    verdict_t         pending_verdicts [$];

    int               mismatches;
    int               quiet_cycles;
    bit               no_idle;

    lwe_clue_detection dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one accepted beat to the shadow state and queues the verdict that
    // an offset beat produces.
    function automatic void detect_apply(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                                         input logic [VAL_W-1:0] raw);
        int unsigned       v;
        longint unsigned   prod;
        int unsigned       acc;
        int unsigned       diff;
        int unsigned       mag;
        verdict_t          verdict;
        v = raw;
        if (v >= MODULUS)
            v = v - MODULUS;
        case (cmd)
            CMD_KEY:
            begin
                if (pos < VECTOR_LENGTH)
                begin
                    secret_copy[pos] = v;
                    key_loaded[pos] = 1'b1;
                end
            end
            CMD_CLUE:
            begin
                if (pos < VECTOR_LENGTH)
                begin
                    prod = longint'(v) * longint'(secret_copy[pos]);
                    acc = clue_sum + int'(prod % MODULUS);
                    if (acc >= MODULUS)
                        acc = acc - MODULUS;
                    clue_sum = acc;
                end
            end
            CMD_OFFSET:
            begin
                if (v >= clue_sum)
                    diff = v - clue_sum;
                else
                    diff = v + MODULUS - clue_sum;
                if (diff > HALF_RANGE)
                begin
                    verdict.centred = VAL_W'(int'(diff) - int'(MODULUS));
                    mag = MODULUS - diff;
                end
                else
                begin
                    verdict.centred = VAL_W'(diff);
                    mag = diff;
                end
                verdict.detected = (mag < threshold_q);
                pending_verdicts = {pending_verdicts, verdict};
                clue_sum = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offset that lands delta away from the current sum, sometimes left unreduced.
    function automatic logic [VAL_W-1:0] offset_near(input int delta);
        longint r;
        r = (longint'(clue_sum) + longint'(delta)) % longint'(MODULUS);
        if (r < 0)
            r = r + MODULUS;
        if (r + MODULUS <= RAW_MAX && $urandom_range(0, 7) == 0)
            r = r + MODULUS;
        return VAL_W'(r);
    endfunction

    function automatic logic [POS_W-1:0] loaded_position();
        int p;
        do
            p = $urandom_range(0, VECTOR_LENGTH - 1);
        while (!key_loaded[p]);
        return POS_W'(p);
    endfunction

    // Sends one beat, with random gaps before it unless idling is switched off.
    // Starts and ends at a falling edge.
    task automatic send_beat(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        while (!no_idle && $urandom_range(0, 99) < 26)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {{(24 - VAL_W - POS_W){1'b0}}, val, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        detect_apply(cmd, pos, val);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Waits for every queued verdict and then lets trailing key and clue beats
    // drain out of the pipeline.
    task automatic wait_idle();
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = thr;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        threshold_q = thr;
    endtask

    // Field extremes and each corner case, under the reset threshold of 17.
    task automatic test_directed();
        send_beat(CMD_KEY, 5'd0, 17'd65536);
        send_beat(CMD_KEY, 5'd24, 17'd1);
        send_beat(CMD_KEY, 5'd1, 17'h1FFFF);      // unreduced, stored as 65534
        send_beat(CMD_KEY, 5'd25, 17'd5);         // out of range, ignored
        send_beat(CMD_KEY, 5'd31, 17'd7);
        send_beat(CMD_CLUE, 5'd0, 17'd65536);     // (-1) * (-1) = 1
        send_beat(CMD_CLUE, 5'd24, 17'd0);
        send_beat(CMD_CLUE, 5'd31, 17'd9);        // out of range, ignored
        send_beat(CMD_UNUSED, 5'd3, 17'd4);
        send_beat(CMD_OFFSET, 5'd0, 17'd1);       // difference zero
        send_beat(CMD_OFFSET, 5'd0, 17'd16);      // just inside the threshold
        send_beat(CMD_OFFSET, 5'd0, 17'd17);      // just outside it
        send_beat(CMD_OFFSET, 5'd0, 17'd65521);   // -16
        send_beat(CMD_OFFSET, 5'd0, 17'd32768);   // top of the centred range
        send_beat(CMD_OFFSET, 5'd0, 17'd32769);   // bottom of the centred range
        send_beat(CMD_OFFSET, 5'd0, 17'd65537);   // reduces to zero
        send_beat(CMD_OFFSET, 5'd31, 17'h1FFFF);  // reduces to 65534, i.e. -3
        // The same element twice in one clue is accumulated twice.
        send_beat(CMD_CLUE, 5'd1, 17'd2);
        send_beat(CMD_CLUE, 5'd1, 17'd2);
        send_beat(CMD_OFFSET, 5'd0, 17'd0);
    endtask

    task automatic test_key_fill();
        for (int p = 0; p < VECTOR_LENGTH; p++)
            send_beat(CMD_KEY, POS_W'(p), VAL_W'($urandom_range(0, RAW_MAX)));
    endtask

    // Offsets placed right on both edges of each threshold setting, plus one random offset.
    task automatic test_threshold_edges();
        logic [THR_W-1:0] settings [5];
        int               t;
        settings = '{16'd0, 16'd1, 16'd32768, 16'hFFFF, THR_W'($urandom_range(1, 32768))};
        foreach (settings[i])
        begin
            write_threshold(settings[i]);
            t = settings[i];
            for (int k = 0; k < 6; k++)
            begin
                repeat ($urandom_range(1, 4))
                    send_beat(CMD_CLUE, loaded_position(), VAL_W'($urandom_range(0, RAW_MAX)));
                case (k)
                    0: send_beat(CMD_OFFSET, 5'd0, offset_near(t - 1));
                    1: send_beat(CMD_OFFSET, 5'd0, offset_near(t));
                    2: send_beat(CMD_OFFSET, 5'd0, offset_near(1 - t));
                    3: send_beat(CMD_OFFSET, 5'd0, offset_near(-t));
                    4: send_beat(CMD_OFFSET, 5'd0, offset_near(0));
                    default: send_beat(CMD_OFFSET, POS_W'($urandom_range(0, 31)),
                                       VAL_W'($urandom_range(0, RAW_MAX)));
                endcase
            end
        end
    endtask

    // Mostly well-formed clues with random content, mixed with key reloads and
    // beats that the block ignores. One phase runs without any idling.
    task automatic test_random_stream();
        int counted;
        int r;
        int span;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph == PHASE_COUNT - 1)
                write_threshold(THR_RESET);
            else
                write_threshold(THR_W'($urandom_range(1, 32768)));
            no_idle = (ph == 2);
            span = (threshold_q > HALF_RANGE ? HALF_RANGE : threshold_q) + 2;
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    send_beat(CMD_KEY, POS_W'($urandom_range(0, 31)),
                              VAL_W'($urandom_range(0, RAW_MAX)));
                    counted++;
                end
                else if (r < 11)
                    send_beat(CMD_UNUSED, POS_W'($urandom_range(0, 31)),
                              VAL_W'($urandom_range(0, RAW_MAX)));
                else if (r < 14)
                    send_beat(CMD_CLUE, POS_W'($urandom_range(VECTOR_LENGTH, 31)),
                              VAL_W'($urandom_range(0, RAW_MAX)));
                else if (r < 28)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_beat(CMD_OFFSET, POS_W'($urandom_range(0, 31)),
                                  offset_near(int'($urandom_range(0, 2 * span)) - span));
                    else
                        send_beat(CMD_OFFSET, POS_W'($urandom_range(0, 31)),
                                  VAL_W'($urandom_range(0, RAW_MAX)));
                    counted++;
                end
                else
                begin
                    send_beat(CMD_CLUE, loaded_position(), VAL_W'($urandom_range(0, RAW_MAX)));
                    counted++;
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // Output side: random backpressure, none while a no-idle phase runs.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = no_idle || ($urandom_range(0, 99) >= 26);
        end
    end

    // Compares every accepted output beat with the oldest queued verdict.
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: output beat with nothing expected: detected=%b data=%h",
                             $realtime, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tuser !== want.detected ||
                    m_axis_tdata !== {{(24 - VAL_W){1'b0}}, want.centred})
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"%0t: verdict mismatch: expected detected=%b diff=%0d, ",
                                  "got detected=%b data=%h"},
                                 $realtime, want.detected, want.centred,
                                 m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_KEY;
        no_idle       = 1'b0;
        clue_sum      = 0;
        threshold_q   = THR_RESET;
        foreach (key_loaded[i])
        begin
            key_loaded[i]  = 1'b0;
            secret_copy[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_key_fill();
        test_threshold_edges();
        test_random_stream();

        wait_idle();
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
